@@ src/button_debounce_press_classifier_defines.svh @@
// ----------------------------------------------------------------------------
// Button debounce press classifier: assertion macros
// Shared assertion forms for the checker, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH

// Assert a property outside reset.
`define BDPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assert a property at every edge, reset included.
`define BDPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/bdpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Button debounce press classifier package
// Timestamp width, phase codes, event codes, register indexes, reset values and the poll record.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 2;

  typedef logic [TimeW-1:0] time_t;
  typedef logic [CfgW-1:0]  cfg_t;

  // Register indexes on the configuration port
  localparam logic [IdxW-1:0] CfgDebounce  = 2'd0;
  localparam logic [IdxW-1:0] CfgLongPress = 2'd1;

  // Phase codes
  localparam logic [1:0] PhIdle        = 2'd0;
  localparam logic [1:0] PhPressPend   = 2'd1;
  localparam logic [1:0] PhPressed     = 2'd2;
  localparam logic [1:0] PhReleasePend = 2'd3;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvShort = 2'd1,
    EvLong  = 2'd2
  } press_ev_e;

  localparam cfg_t DebounceRst  = 16'd50;
  localparam cfg_t LongPressRst = 16'd1000;

  // One registered poll request
  typedef struct packed {
    logic  valid;
    logic  pressed;
    time_t now;
  } poll_t;

endpackage

@@ src/button_debounce_press_classifier.sv @@
// A poll waits in the input register; its event goes to the output register when
// the output is free. Throughput: one poll per cycle while the output is not
// stalled; the state update is one subtract and two compares between the poll
// register and the event register. Reset: asynchronous, active low; clears the
// phase to idle, the edge time and long-press flag to zero; loads debounce 50 ms, long press 1000 ms.
// ----------------------------------------------------------------------------
// Button debounce press classifier
// Short and long press detection with debouncing on raw, timestamped button polls.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bdpc_pkg::IdxW-1:0] cfg_idx_i,
  input  bdpc_pkg::cfg_t            cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      pressed_raw_i,
  input  logic [31:0]               now_ms_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                press_event_o
);
  import bdpc_pkg::*;

  cfg_t  debounce_q;
  cfg_t  long_press_q;
  poll_t poll;
  logic  adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceRst;
      long_press_q <= LongPressRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgDebounce) begin
        debounce_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == CfgLongPress) begin
        long_press_q <= cfg_wdata_i;
      end
    end
  end

  bdpc_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pressed_raw_i (pressed_raw_i),
    .now_ms_i      (TimeW'(now_ms_i)),
    .adv_i         (adv),
    .poll_o        (poll)
  );

  bdpc_fsm u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .poll_i        (poll),
    .debounce_i    (debounce_q),
    .long_press_i  (long_press_q),
    .out_stall_i   (out_stall_i),
    .adv_o         (adv),
    .out_valid_o   (out_valid_o),
    .press_event_o (press_event_o)
  );

endmodule

@@ src/bdpc_in_reg.sv @@
// ----------------------------------------------------------------------------
// Poll input register
// Captures one poll request and holds it until the classifier takes it.
// ----------------------------------------------------------------------------
module bdpc_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           pressed_raw_i,
  input  bdpc_pkg::time_t now_ms_i,
  input  logic           adv_i,
  output bdpc_pkg::poll_t poll_o
);
  import bdpc_pkg::*;

  logic  valid_q, valid_d;
  logic  pressed_q;
  time_t now_q;
  logic  load;

  // Take a new request when empty or when the held one moves on
  assign load       = !valid_q || adv_i;
  assign in_stall_o = !load;
  assign valid_d    = load ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      pressed_q <= pressed_raw_i;
      now_q     <= now_ms_i;
    end
  end

  assign poll_o = '{valid: valid_q, pressed: pressed_q, now: now_q};

endmodule

@@ src/bdpc_fsm.sv @@
// ----------------------------------------------------------------------------
// Press classifier state machine
// Debounces press and release and registers one event per poll.
// ----------------------------------------------------------------------------
module bdpc_fsm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bdpc_pkg::poll_t poll_i,
  input  bdpc_pkg::cfg_t  debounce_i,
  input  bdpc_pkg::cfg_t  long_press_i,
  input  logic            out_stall_i,
  output logic            adv_o,
  output logic            out_valid_o,
  output logic [1:0]      press_event_o
);
  import bdpc_pkg::*;

  logic [1:0] phase_q, phase_d;
  time_t      edge_q, edge_d;
  logic       long_q, long_d;
  logic       out_valid_q, out_valid_d;
  press_ev_e  ev_q, ev_d;

  time_t elapsed;
  logic  deb_met;
  logic  long_met;
  logic  step;

  assign adv_o = !out_valid_q || !out_stall_i;
  assign step  = poll_i.valid && adv_o;

  assign elapsed  = poll_i.now - edge_q;
  assign deb_met  = elapsed >= {{(TimeW-CfgW){1'b0}}, debounce_i};
  assign long_met = elapsed >= {{(TimeW-CfgW){1'b0}}, long_press_i};

  always_comb begin
    phase_d = phase_q;
    edge_d  = edge_q;
    long_d  = long_q;
    ev_d    = EvNone;
    unique case (phase_q)
      PhIdle: begin
        if (poll_i.pressed) begin
          phase_d = PhPressPend;
          edge_d  = poll_i.now;
          long_d  = 1'b0;
        end
      end
      PhPressPend: begin
        if (!poll_i.pressed) begin
          phase_d = PhIdle;
        end else if (deb_met) begin
          phase_d = PhPressed;
        end
      end
      PhPressed: begin
        // Long press wins; release is looked at on the next poll
        if (!long_q && long_met) begin
          long_d = 1'b1;
          ev_d   = EvLong;
        end else if (!poll_i.pressed) begin
          phase_d = PhReleasePend;
          edge_d  = poll_i.now;
        end
      end
      PhReleasePend: begin
        // Bounce back keeps the release-edge time
        if (poll_i.pressed) begin
          phase_d = PhPressed;
        end else if (deb_met) begin
          phase_d = PhIdle;
          if (!long_q) begin
            ev_d = EvShort;
          end
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  assign out_valid_d = step ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      edge_q      <= '0;
      long_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        phase_q <= phase_d;
        edge_q  <= edge_d;
        long_q  <= long_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      ev_q <= ev_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign press_event_o = ev_q;

endmodule

@@ src/bdpc_checker.sv @@
// ----------------------------------------------------------------------------
// Press classifier port checker
// Watches the top-level ports for event coding, stall and reset behavior.
// ----------------------------------------------------------------------------
`include "button_debounce_press_classifier_defines.svh"

module bdpc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_we_i,
  input logic [bdpc_pkg::IdxW-1:0] cfg_idx_i,
  input bdpc_pkg::cfg_t            cfg_wdata_i,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      pressed_raw_i,
  input logic [31:0]               now_ms_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [1:0]                press_event_o
);
  import bdpc_pkg::*;

  `BDPC_ASSERT(a_ev_code, out_valid_o |-> (press_event_o != 2'd3), "unused event code")

  `BDPC_ASSERT(a_ev_hold, (out_valid_o && out_stall_i) |=> $stable(press_event_o), "event moved")

  // Two long presses need a whole new press cycle in between
  `BDPC_ASSERT(a_long_gap, (out_valid_o && !out_stall_i && press_event_o == EvLong) |=> !(out_valid_o && press_event_o == EvLong), "long press twice in a row")

  `BDPC_ASSERT(a_no_stall_empty, !out_valid_o |-> !in_stall_o, "input stalled with empty output")

  `BDPC_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (.*);
